// File: rtl/smma_pkg.sv
// shared types and constants of the square matrix multiply-accumulate block
// item structs, command codes and register indexes; no dependencies
`timescale 1ns / 1ps

package smma_pkg;

  // default largest matrix side
  localparam int MAX_SIDE_DEF = 8;

  // fixed field widths
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 7;
  localparam int REG_W   = 2;

  // item modes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_LOAD_C  = 2'd2;
  localparam logic [1:0] MODE_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_SIDE  = 2'd0;
  localparam logic [REG_W-1:0] REG_FIRST = 2'd1;
  localparam logic [REG_W-1:0] REG_END   = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]                mode;
    logic [INDEX_W-1:0]        elem_index;
    logic signed [VALUE_W-1:0] elem_value;
  } in_t;

  // result item
  typedef struct packed {
    logic [INDEX_W-1:0]        out_index;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    logic                      compute;
    logic [1:0]                store;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // configuration write
  typedef struct packed {
    logic             write;
    logic [REG_W-1:0] index;
    logic [CFG_W-1:0] data;
  } cfg_t;

endpackage

// File: rtl/square_matrix_multiply_accumulate.sv
// Square matrix multiply-accumulate in signed Q16.16. Items enter a two-entry
// command queue; load items write one element of A, B or C. A compute item
// with first_index below the clamped end first splits first_index into row and
// column by repeated subtraction of side, then for each result element issues
// its products one at a time through the single 32x32 multiplier and the one
// read port of each store, drains the read, multiply and accumulate pipeline
// and writes the result back; other compute items are taken with no results.
// Results wait in a four-entry queue; the engine stops while that queue is
// full. Stores are not cleared at reset.
// top level; depends on smma_pkg, smma_front, smma_engine and smma_fifo
`timescale 1ns / 1ps

module square_matrix_multiply_accumulate #(
  parameter int MAX_SIDE = smma_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  smma_pkg::in_t                 request,
  output logic                          empty,
  input  logic                          pop,
  output smma_pkg::out_t                result,
  input  logic                          cfg_write,
  input  logic [smma_pkg::REG_W-1:0]    cfg_index,
  input  logic [smma_pkg::CFG_W-1:0]    cfg_data
);

  smma_pkg::cmd_t cmd;
  smma_pkg::cfg_t cfg;
  smma_pkg::out_t res;
  logic           cmd_valid;
  logic           cmd_take;
  logic           res_valid;
  logic           res_full;

  // configuration bundle
  always_comb begin
    cfg.write = cfg_write;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  // front: accept and classify items
  smma_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  // back: stores and multiply-accumulate
  smma_engine #(
    .MAX_SIDE (MAX_SIDE)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (!res_full)
  );

  // result queue
  smma_fifo #(
    .WIDTH ($bits(smma_pkg::out_t)),
    .DEPTH (4)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

// File: rtl/smma_fifo.sv
// small first-in first-out queue of flat words
// no package dependencies; used for the command and result queues
`timescale 1ns / 1ps

module smma_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/smma_front.sv
// front end: accepts items, classifies them and queues commands for the engine
// depends on smma_pkg and smma_fifo
`timescale 1ns / 1ps

module smma_front #(
  parameter int MAX_SIDE = smma_pkg::MAX_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  smma_pkg::in_t   request,
  output smma_pkg::cmd_t  cmd,
  output logic            cmd_valid,
  input  logic            cmd_take
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;

  smma_pkg::cmd_t cmd_in;
  logic           keep;
  logic           cmd_empty;

  // classify: loads outside the stores are accepted and dropped
  always_comb begin
    cmd_in.compute = (request.mode == smma_pkg::MODE_COMPUTE);
    cmd_in.store   = request.mode;
    cmd_in.index   = request.elem_index;
    cmd_in.value   = request.elem_value;
    keep = cmd_in.compute ||
           ({1'b0, request.elem_index} < (smma_pkg::INDEX_W + 1)'(DEPTH));
  end

  smma_fifo #(
    .WIDTH ($bits(smma_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && keep),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_take),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// File: rtl/smma_engine.sv
// back end: matrix stores, configuration registers and the multiply-accumulate sequencer
// depends on smma_pkg
`timescale 1ns / 1ps

module smma_engine #(
  parameter int MAX_SIDE = smma_pkg::MAX_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  smma_pkg::cfg_t  cfg,
  input  smma_pkg::cmd_t  cmd,
  input  logic            cmd_valid,
  output logic            cmd_take,
  output smma_pkg::out_t  res,
  output logic            res_valid,
  input  logic            res_ready
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] MAX_S = 4'(MAX_SIDE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  // saturating add of a shifted product to a running sum
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [63:0] p);
    logic signed [48:0] sum;
    logic signed [31:0] r;
    sum = {{17{a[31]}}, a} + {p[63], p[63:16]};
    if (!sum[48] && (|sum[47:31])) begin
      r = 32'sh7fff_ffff;
    end else if (sum[48] && !(&sum[47:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [3:0] side;
  logic [6:0] first_index;
  logic [6:0] end_index;

  // sequencer registers
  logic [2:0] state;
  logic [3:0] s_eff;
  logic [6:0] stop;
  logic [6:0] idx;
  logic [6:0] row0;
  logic [6:0] col;
  logic [3:0] j;
  logic [6:0] b_addr;

  // pipeline registers
  logic               v1;
  logic               v2;
  logic               first1;
  logic signed [31:0] a_q;
  logic signed [31:0] b_q;
  logic signed [31:0] c_q;
  logic signed [63:0] prod;
  logic signed [31:0] acc;

  // stores
  logic signed [31:0] a_mem [DEPTH];
  logic signed [31:0] b_mem [DEPTH];
  logic signed [31:0] c_mem [DEPTH];

  logic [3:0] s_c;
  logic [7:0] ss;
  logic [6:0] stop_c;
  logic [6:0] a_addr;
  logic       is_last;
  logic       load_go;
  logic       c_we;
  logic [ADDR_W-1:0] c_waddr;
  logic signed [31:0] c_wdata;
  logic [6:0] col_next;
  logic [6:0] row0_next;

  // effective side and clamped end
  always_comb begin
    if (side == 4'd0) begin
      s_c = 4'd1;
    end else if (side > MAX_S) begin
      s_c = MAX_S;
    end else begin
      s_c = side;
    end
    ss     = {4'd0, s_c} * {4'd0, s_c};
    stop_c = (end_index > ss[6:0]) ? ss[6:0] : end_index;
  end

  assign a_addr  = row0 + {3'd0, j};
  assign is_last = ((idx + 7'd1) == stop);
  assign load_go = (state == S_IDLE) && cmd_valid && !cmd.compute;

  // position of the next result element
  always_comb begin
    if ((col + 7'd1) == {3'd0, s_eff}) begin
      col_next  = '0;
      row0_next = row0 + {3'd0, s_eff};
    end else begin
      col_next  = col + 7'd1;
      row0_next = row0;
    end
  end

  // result store write port: loads or write-back
  always_comb begin
    c_we    = 1'b0;
    c_waddr = cmd.index[ADDR_W-1:0];
    c_wdata = cmd.value;
    if (load_go && (cmd.store == smma_pkg::MODE_LOAD_C)) begin
      c_we = 1'b1;
    end else if ((state == S_WRITE) && res_ready) begin
      c_we    = 1'b1;
      c_waddr = idx[ADDR_W-1:0];
      c_wdata = acc;
    end
  end

  // handshakes
  always_comb begin
    cmd_take = 1'b0;
    case (state)
      S_IDLE:  cmd_take = cmd_valid && (!cmd.compute || (first_index >= stop_c));
      S_WRITE: cmd_take = res_ready && is_last;
      default: cmd_take = 1'b0;
    endcase
  end

  assign res_valid     = (state == S_WRITE);
  assign res.out_index = idx[5:0];
  assign res.out_value = acc;
  assign res.last      = is_last;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      side        <= 4'd8;
      first_index <= 7'd0;
      end_index   <= 7'd64;
    end else if (cfg.write) begin
      case (cfg.index)
        smma_pkg::REG_SIDE:  side        <= cfg.data[3:0];
        smma_pkg::REG_FIRST: first_index <= cfg.data;
        smma_pkg::REG_END:   end_index   <= cfg.data;
        default: ;
      endcase
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (load_go && (cmd.store == smma_pkg::MODE_LOAD_A)) begin
      a_mem[cmd.index[ADDR_W-1:0]] <= cmd.value;
    end
    if (load_go && (cmd.store == smma_pkg::MODE_LOAD_B)) begin
      b_mem[cmd.index[ADDR_W-1:0]] <= cmd.value;
    end
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
  end

  // store reads, registered
  always_ff @(posedge clk) begin
    a_q <= a_mem[a_addr[ADDR_W-1:0]];
    b_q <= b_mem[b_addr[ADDR_W-1:0]];
    c_q <= c_mem[idx[ADDR_W-1:0]];
  end

  // multiply and accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      first1 <= 1'b0;
    end else begin
      v1     <= (state == S_ISSUE);
      first1 <= (state == S_ISSUE) && (j == 4'd0);
      v2     <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= a_q * b_q;
    end
    if (v1 && first1) begin
      acc <= c_q;
    end else if (v2) begin
      acc <= sat_add(acc, prod);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.compute && (first_index < stop_c)) begin
            s_eff <= s_c;
            stop  <= stop_c;
            idx   <= first_index;
            col   <= first_index;
            row0  <= '0;
            state <= S_DIV;
          end
        end
        // split the first position into row start and column
        S_DIV: begin
          if (col >= {3'd0, s_eff}) begin
            col  <= col - {3'd0, s_eff};
            row0 <= row0 + {3'd0, s_eff};
          end else begin
            j      <= '0;
            b_addr <= col;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          j      <= j + 4'd1;
          b_addr <= b_addr + {3'd0, s_eff};
          if (j == (s_eff - 4'd1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (res_ready) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx    <= idx + 7'd1;
              col    <= col_next;
              row0   <= row0_next;
              j      <= '0;
              b_addr <= col_next;
              state  <= S_ISSUE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
